// ===== hdl/sld_pkg.sv =====
// Shared types, codes and the CRC-32 byte update for the frame deframer.
`default_nettype none
package sld_pkg;

	localparam int unsigned MIN_SCAN = 14;
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [7:0] SUB_VOLTAGE = 8'h0C;
	localparam logic [7:0] SUB_CAPACITY = 8'h0B;

	localparam logic [31:0] SEED_RST = 32'h35769521;
	localparam logic [10:0] MAX_TL_RST = 11'h500;
	localparam logic [7:0] SYNC_RST = 8'hA5;
	localparam logic [7:0] END_RST = 8'h5A;

	localparam logic [1:0] REQ_PUSH = 2'd0;
	localparam logic [1:0] REQ_READ = 2'd1;
	localparam logic [1:0] REQ_SERVICE = 2'd2;
	localparam logic [1:0] REQ_NONE = 2'd3;

	localparam logic [1:0] EVT_FRAME = 2'd0;
	localparam logic [1:0] EVT_CRC_ERR = 2'd1;
	localparam logic [1:0] EVT_READ = 2'd2;

	localparam logic [1:0] QRY_NONE = 2'd0;
	localparam logic [1:0] QRY_VOLTAGE = 2'd1;
	localparam logic [1:0] QRY_CAPACITY = 2'd2;

	localparam logic [1:0] CFG_CRC_SEED = 2'd0;
	localparam logic [1:0] CFG_MAX_TL = 2'd1;
	localparam logic [1:0] CFG_SYNC = 2'd2;
	localparam logic [1:0] CFG_END = 2'd3;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] rx_byte;
		logic [10:0] read_index;
	} req_t;

	typedef struct packed {
		logic [1:0] event_kind;
		logic [7:0] version;
		logic [7:0] main_cmd;
		logic [7:0] sub_cmd;
		logic [7:0] ack_code;
		logic [10:0] data_len;
		logic [1:0] query_kind;
		logic more_pending;
		logic [7:0] read_data;
	} evt_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_TEST, ST_SYNC, ST_TL0, ST_TL1, ST_LEN, ST_END, ST_D0, ST_D1,
		ST_VER, ST_MAIN, ST_SUB, ST_ACK, ST_CRC, ST_R0, ST_R1, ST_R2, ST_R3,
		ST_RDW, ST_EMIT
	} st_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/sync_length_crc32_deframer_unit.sv =====
// A push or service scans from ST_TEST and answers a checked frame after the CRC walk and
// ST_R0 to ST_R3; each dropped byte returns the scan to ST_TEST. A read answers via ST_RDW.
// Throughput: one request at a time; the byte store's single read port paces the CRC walk
// at one byte per cycle.
// Reset clears pointers, counts, config and evt_valid; not the byte store or frame fields.
`default_nettype none
module sync_length_crc32_deframer_unit #(
	parameter int STORE_DEPTH = 2048
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input wire sld_pkg::req_t req,
	output logic evt_valid,
	input wire logic evt_stall,
	output sld_pkg::evt_t evt,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [31:0] cfg_wdata
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int FW = AW + 1;

	logic [7:0] mem [STORE_DEPTH];
	logic [7:0] rdata_q;
	logic [AW-1:0] rd_addr;
	logic mem_we;

	sld_pkg::st_t state_q, state_d;
	logic [AW-1:0] start_q, pbase_q;
	logic [FW-1:0] fill_q;
	logic [10:0] held_q, tl_q, dlen_q, walk_q;
	logic [7:0] tl_lo_q, d_lo_q, ver_q, main_q, sub_q, ack_q, r0_q, r1_q, r2_q;
	logic [31:0] crc_q, seed_q;
	logic [10:0] max_tl_q;
	logic [7:0] sync_q, end_q;
	logic wp_q, hit_q;
	sld_pkg::evt_t res_q, evt_q;
	logic evt_valid_q;

	logic acc, drop, stop, emit_go, crc_last, crc_ok;
	logic [1:0] qry;
	logic [15:0] tl16, d16;
	logic [FW-1:0] fl, fill_after;
	logic [31:0] recv;

	assign acc = req_valid && !req_stall;
	assign tl16 = {rdata_q, tl_lo_q};
	assign d16 = {rdata_q, d_lo_q};
	assign fl = FW'(tl_q) + FW'(9);
	assign crc_last = (walk_q + 11'd1) >= tl_q;
	assign recv = {rdata_q, r2_q, r1_q, r0_q};
	assign crc_ok = (recv == ~crc_q);
	assign qry = (!crc_ok || ack_q != 8'd1 || main_q != 8'd1 || dlen_q != 11'd0) ?
		sld_pkg::QRY_NONE :
		(sub_q == sld_pkg::SUB_VOLTAGE) ? sld_pkg::QRY_VOLTAGE :
		(sub_q == sld_pkg::SUB_CAPACITY) ? sld_pkg::QRY_CAPACITY : sld_pkg::QRY_NONE;
	assign emit_go = !evt_valid_q || !evt_stall;
	assign mem_we = acc && (req.req_type == sld_pkg::REQ_PUSH) &&
		(fill_q != FW'(STORE_DEPTH));
	assign fill_after = crc_ok ? (fill_q - fl) : (fill_q - FW'(1));
	assign evt_valid = evt_valid_q;
	assign evt = evt_q;

	always_comb begin
		state_d = state_q;
		rd_addr = start_q;
		drop = 1'b0;
		stop = 1'b0;
		req_stall = (state_q != sld_pkg::ST_IDLE);
		case (state_q)
			sld_pkg::ST_IDLE: begin
				rd_addr = pbase_q + AW'(req.read_index);
				if (acc) begin
					case (req.req_type)
						sld_pkg::REQ_PUSH, sld_pkg::REQ_SERVICE: state_d = sld_pkg::ST_TEST;
						sld_pkg::REQ_READ: state_d = sld_pkg::ST_RDW;
						default: state_d = sld_pkg::ST_IDLE;
					endcase
				end
			end
			sld_pkg::ST_TEST: begin
				if (fill_q < FW'(sld_pkg::MIN_SCAN)) begin
					stop = 1'b1;
					state_d = sld_pkg::ST_IDLE;
				end else begin
					state_d = sld_pkg::ST_SYNC;
				end
			end
			sld_pkg::ST_SYNC: begin
				rd_addr = start_q + AW'(2);
				if (rdata_q != sync_q) begin
					drop = 1'b1;
					state_d = sld_pkg::ST_TEST;
				end else begin
					state_d = sld_pkg::ST_TL0;
				end
			end
			sld_pkg::ST_TL0: begin
				rd_addr = start_q + AW'(3);
				state_d = sld_pkg::ST_TL1;
			end
			sld_pkg::ST_TL1: begin
				if (tl16 > {5'd0, max_tl_q}) begin
					drop = 1'b1;
					state_d = sld_pkg::ST_TEST;
				end else begin
					state_d = sld_pkg::ST_LEN;
				end
			end
			sld_pkg::ST_LEN: begin
				rd_addr = start_q + AW'(fl - FW'(1));
				if (fl > fill_q) begin
					if (fill_q == FW'(STORE_DEPTH)) begin
						drop = 1'b1;
						state_d = sld_pkg::ST_TEST;
					end else begin
						stop = 1'b1;
						state_d = sld_pkg::ST_IDLE;
					end
				end else begin
					state_d = sld_pkg::ST_END;
				end
			end
			sld_pkg::ST_END: begin
				rd_addr = start_q + AW'(7);
				if (rdata_q != end_q) begin
					drop = 1'b1;
					state_d = sld_pkg::ST_TEST;
				end else begin
					state_d = sld_pkg::ST_D0;
				end
			end
			sld_pkg::ST_D0: begin
				rd_addr = start_q + AW'(8);
				state_d = sld_pkg::ST_D1;
			end
			sld_pkg::ST_D1: begin
				rd_addr = start_q + AW'(1);
				if ({6'd0, tl_q} != ({1'b0, d16} + 17'd5)) begin
					drop = 1'b1;
					state_d = sld_pkg::ST_TEST;
				end else begin
					state_d = sld_pkg::ST_VER;
				end
			end
			sld_pkg::ST_VER: begin
				rd_addr = start_q + AW'(4);
				state_d = sld_pkg::ST_MAIN;
			end
			sld_pkg::ST_MAIN: begin
				rd_addr = start_q + AW'(5);
				state_d = sld_pkg::ST_SUB;
			end
			sld_pkg::ST_SUB: begin
				rd_addr = start_q + AW'(6);
				state_d = sld_pkg::ST_ACK;
			end
			sld_pkg::ST_ACK: begin
				rd_addr = start_q + AW'(4);
				state_d = sld_pkg::ST_CRC;
			end
			sld_pkg::ST_CRC: begin
				if (crc_last) begin
					rd_addr = start_q + AW'(dlen_q) + AW'(9);
					state_d = sld_pkg::ST_R0;
				end else begin
					rd_addr = start_q + AW'(walk_q) + AW'(5);
				end
			end
			sld_pkg::ST_R0: begin
				rd_addr = start_q + AW'(dlen_q) + AW'(10);
				state_d = sld_pkg::ST_R1;
			end
			sld_pkg::ST_R1: begin
				rd_addr = start_q + AW'(dlen_q) + AW'(11);
				state_d = sld_pkg::ST_R2;
			end
			sld_pkg::ST_R2: begin
				rd_addr = start_q + AW'(dlen_q) + AW'(12);
				state_d = sld_pkg::ST_R3;
			end
			sld_pkg::ST_R3: state_d = sld_pkg::ST_EMIT;
			sld_pkg::ST_RDW: state_d = sld_pkg::ST_EMIT;
			sld_pkg::ST_EMIT: begin
				if (emit_go) begin
					state_d = sld_pkg::ST_IDLE;
				end
			end
			default: state_d = sld_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[start_q + AW'(fill_q)] <= req.rx_byte;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sld_pkg::ST_IDLE;
			start_q <= '0;
			pbase_q <= '0;
			fill_q <= '0;
			held_q <= '0;
			wp_q <= 1'b0;
			evt_valid_q <= 1'b0;
			seed_q <= sld_pkg::SEED_RST;
			max_tl_q <= sld_pkg::MAX_TL_RST;
			sync_q <= sld_pkg::SYNC_RST;
			end_q <= sld_pkg::END_RST;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					sld_pkg::CFG_CRC_SEED: seed_q <= cfg_wdata;
					sld_pkg::CFG_MAX_TL: max_tl_q <= cfg_wdata[10:0];
					sld_pkg::CFG_SYNC: sync_q <= cfg_wdata[7:0];
					sld_pkg::CFG_END: end_q <= cfg_wdata[7:0];
					default: ;
				endcase
			end
			if (mem_we) begin
				fill_q <= fill_q + FW'(1);
			end
			if (drop) begin
				start_q <= start_q + AW'(1);
				fill_q <= fill_q - FW'(1);
			end
			if (stop) begin
				wp_q <= 1'b0;
			end
			if (state_q == sld_pkg::ST_R3) begin
				wp_q <= fill_after >= FW'(sld_pkg::MIN_SCAN);
				fill_q <= fill_after;
				if (crc_ok) begin
					start_q <= start_q + AW'(fl);
					pbase_q <= start_q + AW'(9);
					held_q <= dlen_q;
				end else begin
					start_q <= start_q + AW'(1);
				end
			end
			if (state_q == sld_pkg::ST_EMIT && emit_go) begin
				evt_valid_q <= 1'b1;
			end else if (evt_valid_q && !evt_stall) begin
				evt_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			sld_pkg::ST_IDLE: hit_q <= req.read_index < held_q;
			sld_pkg::ST_TL0: tl_lo_q <= rdata_q;
			sld_pkg::ST_TL1: tl_q <= tl16[10:0];
			sld_pkg::ST_D0: d_lo_q <= rdata_q;
			sld_pkg::ST_D1: dlen_q <= d16[10:0];
			sld_pkg::ST_VER: ver_q <= rdata_q;
			sld_pkg::ST_MAIN: main_q <= rdata_q;
			sld_pkg::ST_SUB: sub_q <= rdata_q;
			sld_pkg::ST_ACK: begin
				ack_q <= rdata_q;
				crc_q <= ~seed_q;
				walk_q <= '0;
			end
			sld_pkg::ST_CRC: begin
				crc_q <= sld_pkg::crc_byte(crc_q, rdata_q);
				walk_q <= walk_q + 11'd1;
			end
			sld_pkg::ST_R0: r0_q <= rdata_q;
			sld_pkg::ST_R1: r1_q <= rdata_q;
			sld_pkg::ST_R2: r2_q <= rdata_q;
			sld_pkg::ST_R3: begin
				res_q <= '{
					event_kind: crc_ok ? sld_pkg::EVT_FRAME : sld_pkg::EVT_CRC_ERR,
					version: ver_q,
					main_cmd: main_q,
					sub_cmd: sub_q,
					ack_code: ack_q,
					data_len: dlen_q,
					query_kind: qry,
					more_pending: fill_after >= FW'(sld_pkg::MIN_SCAN),
					read_data: 8'd0
				};
			end
			sld_pkg::ST_RDW: begin
				res_q <= '{
					event_kind: sld_pkg::EVT_READ,
					version: 8'd0,
					main_cmd: 8'd0,
					sub_cmd: 8'd0,
					ack_code: 8'd0,
					data_len: 11'd0,
					query_kind: sld_pkg::QRY_NONE,
					more_pending: wp_q,
					read_data: hit_q ? rdata_q : 8'd0
				};
			end
			sld_pkg::ST_EMIT: begin
				if (emit_go) begin
					evt_q <= res_q;
				end
			end
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(STORE_DEPTH))
		else $error("fill count beyond store depth");
	a_push_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.req_type == sld_pkg::REQ_PUSH) |=> state_q == sld_pkg::ST_TEST)
		else $error("push did not start a scan");
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sld_pkg::ST_CRC |-> walk_q < tl_q)
		else $error("CRC walk past total length");
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sld_pkg::ST_EMIT && !emit_go) |=> state_q == sld_pkg::ST_EMIT)
		else $error("result left before output register freed");
`endif

endmodule
`default_nettype wire

// ===== bench/sync_length_crc32_deframer_unit_checker.sv =====
// Checker: watches both channels and the register port, predicts events, compares them.
`timescale 1ns / 100ps
module sync_length_crc32_deframer_unit_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire sld_pkg::req_t req,
	input wire logic evt_valid,
	input wire logic evt_stall,
	input wire sld_pkg::evt_t evt,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [31:0] cfg_wdata,
	output int unsigned errors,
	output int unsigned pending
);

	localparam int unsigned DEPTH = 2048;

	logic [7:0] rx_mem [DEPTH];
	int unsigned head, fill, pay_base, pay_len;
	bit busy;
	logic [31:0] seed_r;
	logic [10:0] max_tl_r;
	logic [7:0] sync_r, end_r;
	sld_pkg::evt_t expected_events[$];

	function automatic logic [7:0] at(input int unsigned k);
		return rx_mem[(head + k) % DEPTH];
	endfunction

	function automatic void drop(input int unsigned n);
		head = (head + n) % DEPTH;
		fill -= n;
	endfunction

	function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c;
		for (int i = 0; i < 8; i++) begin
			if (r[0] ^ b[i])
				r = (r >> 1) ^ 32'hEDB88320;
			else
				r = r >> 1;
		end
		return r;
	endfunction

	function automatic bit scan_frames(output sld_pkg::evt_t e);
		int unsigned tl, fl, dl;
		logic [31:0] c, rx;
		e = '0;
		while (fill >= sld_pkg::MIN_SCAN) begin
			if (at(0) != sync_r) begin
				drop(1);
				continue;
			end
			tl = {16'd0, at(3), at(2)};
			if (tl > max_tl_r) begin
				drop(1);
				continue;
			end
			fl = tl + 9;
			if (fl > fill) begin
				if (fill >= DEPTH) begin
					drop(1);
					continue;
				end
				break;
			end
			if (at(fl - 1) != end_r) begin
				drop(1);
				continue;
			end
			dl = {16'd0, at(8), at(7)};
			if (tl != dl + 5) begin
				drop(1);
				continue;
			end
			c = ~seed_r;
			for (int unsigned k = 0; k < tl; k++)
				c = crc_step(c, at(4 + k));
			c = ~c;
			rx = {at(12 + dl), at(11 + dl), at(10 + dl), at(9 + dl)};
			e.version = at(1);
			e.main_cmd = at(4);
			e.sub_cmd = at(5);
			e.ack_code = at(6);
			e.data_len = dl[10:0];
			e.query_kind = sld_pkg::QRY_NONE;
			if (c != rx) begin
				e.event_kind = sld_pkg::EVT_CRC_ERR;
				drop(1);
			end else begin
				e.event_kind = sld_pkg::EVT_FRAME;
				if (at(6) == 8'd1 && at(4) == 8'd1 && dl == 0) begin
					if (at(5) == sld_pkg::SUB_VOLTAGE)
						e.query_kind = sld_pkg::QRY_VOLTAGE;
					else if (at(5) == sld_pkg::SUB_CAPACITY)
						e.query_kind = sld_pkg::QRY_CAPACITY;
				end
				pay_base = (head + 9) % DEPTH;
				pay_len = dl;
				drop(fl);
			end
			busy = fill >= sld_pkg::MIN_SCAN;
			e.more_pending = busy;
			return 1'b1;
		end
		busy = 1'b0;
		return 1'b0;
	endfunction

	function automatic void check_field(input string name, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sld_pkg::evt_t e, x;
		if (!arst_n) begin
			head = 0;
			fill = 0;
			pay_base = 0;
			pay_len = 0;
			busy = 1'b0;
			seed_r = sld_pkg::SEED_RST;
			max_tl_r = sld_pkg::MAX_TL_RST;
			sync_r = sld_pkg::SYNC_RST;
			end_r = sld_pkg::END_RST;
			expected_events.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					sld_pkg::CFG_CRC_SEED: seed_r = cfg_wdata;
					sld_pkg::CFG_MAX_TL: max_tl_r = cfg_wdata[10:0];
					sld_pkg::CFG_SYNC: sync_r = cfg_wdata[7:0];
					sld_pkg::CFG_END: end_r = cfg_wdata[7:0];
					default: ;
				endcase
			end
			if (evt_valid && !evt_stall) begin
				if (expected_events.size() == 0) begin
					$error("unexpected event transaction: %h", evt);
					errors++;
				end else begin
					x = expected_events.pop_front();
					check_field("event_kind", x.event_kind, evt.event_kind);
					check_field("version", x.version, evt.version);
					check_field("main_cmd", x.main_cmd, evt.main_cmd);
					check_field("sub_cmd", x.sub_cmd, evt.sub_cmd);
					check_field("ack_code", x.ack_code, evt.ack_code);
					check_field("data_len", x.data_len, evt.data_len);
					check_field("query_kind", x.query_kind, evt.query_kind);
					check_field("more_pending", x.more_pending, evt.more_pending);
					check_field("read_data", x.read_data, evt.read_data);
				end
			end
			if (req_valid && !req_stall) begin
				case (req.req_type)
					sld_pkg::REQ_PUSH: begin
						if (fill < DEPTH) begin
							rx_mem[(head + fill) % DEPTH] = req.rx_byte;
							fill++;
						end
						if (scan_frames(e))
							expected_events.push_back(e);
					end
					sld_pkg::REQ_SERVICE: begin
						if (scan_frames(e))
							expected_events.push_back(e);
					end
					sld_pkg::REQ_READ: begin
						e = '0;
						e.event_kind = sld_pkg::EVT_READ;
						e.more_pending = busy;
						if (req.read_index < pay_len)
							e.read_data = rx_mem[(pay_base + req.read_index) % DEPTH];
						expected_events.push_back(e);
					end
					default: ;
				endcase
			end
			pending = expected_events.size();
		end
	end

endmodule

// ===== bench/sync_length_crc32_deframer_unit_tb.sv =====
// Testbench top: clock, reset, frame stimulus, register writes and the verdict.
`timescale 1ns / 100ps
module sync_length_crc32_deframer_unit_tb;

	localparam int unsigned QUIET_LIMIT = 100000;
	localparam int unsigned SETTLE = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	sld_pkg::req_t req = '0;
	logic evt_valid;
	logic evt_stall = 1'b0;
	sld_pkg::evt_t evt;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = sld_pkg::CFG_CRC_SEED;
	logic [31:0] cfg_wdata = '0;

	int unsigned errors, pending, quiet, items;
	int unsigned send_pct, recv_pct, hold_cnt;
	bit hold_req, hold_used;
	logic [31:0] seed_m;
	logic [10:0] max_tl_m;
	logic [7:0] sync_m, end_m;

	sync_length_crc32_deframer_unit dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.evt_valid(evt_valid), .evt_stall(evt_stall), .evt(evt),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	sync_length_crc32_deframer_unit_checker chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.evt_valid(evt_valid), .evt_stall(evt_stall), .evt(evt),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.errors(errors), .pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (hold_req && !hold_used) begin
			hold_used = 1'b1;
			hold_cnt = 3000;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			evt_stall <= 1'b1;
		end else
			evt_stall <= ($urandom_range(99) < recv_pct);
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (evt_valid && !evt_stall) || cfg_we)
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic [31:0] crc_add(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		repeat (8) r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
		return r;
	endfunction

	task automatic send(input logic [1:0] kind, input logic [7:0] b, input logic [10:0] idx);
		if ($urandom_range(99) < send_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= '{req_type: kind, rx_byte: b, read_index: idx};
		do @(posedge clk); while (req_stall);
		if (kind != sld_pkg::REQ_NONE)
			items++;
	endtask

	// fault: 0 good, 1 bad CRC, 2 bad end, 3 length mismatch, 4 TL below 5, 5 TL over max
	task automatic push_frame(input logic [7:0] ver, mcmd, scmd, ack, input int unsigned d,
			input int unsigned fault);
		logic [7:0] bytes[$];
		logic [31:0] c;
		int unsigned tl, dl;
		tl = d + 5;
		dl = d;
		if (fault == 3)
			dl = d + $urandom_range(1, 3);
		if (fault == 4)
			tl = $urandom_range(0, 4);
		if (fault == 5)
			tl = max_tl_m + $urandom_range(1, 40);
		bytes = {sync_m, ver, tl[7:0], tl[15:8], mcmd, scmd, ack, dl[7:0], dl[15:8]};
		repeat (d) bytes.push_back(8'($urandom_range(255)));
		c = ~seed_m;
		for (int i = 4; i < bytes.size(); i++)
			c = crc_add(c, bytes[i]);
		c = ~c;
		if (fault == 1)
			c ^= 32'd1 << $urandom_range(31);
		bytes.push_back(c[7:0]);
		bytes.push_back(c[15:8]);
		bytes.push_back(c[23:16]);
		bytes.push_back(c[31:24]);
		bytes.push_back(fault == 2 ? ~end_m : end_m);
		foreach (bytes[i])
			send(sld_pkg::REQ_PUSH, bytes[i], 11'($urandom_range(2047)));
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (pending != 0 || req_stall) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_regs(input logic [31:0] s, input logic [10:0] m, input logic [7:0] sy,
			input logic [7:0] en);
		logic [31:0] vals[4];
		vals = '{s, {21'd0, m}, {24'd0, sy}, {24'd0, en}};
		seed_m = s;
		max_tl_m = m;
		sync_m = sy;
		end_m = en;
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= i[1:0];
			cfg_wdata <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_random(input int unsigned n);
		int unsigned stop, r, d, lim;
		stop = items + n;
		while (items < stop) begin
			r = $urandom_range(99);
			lim = (max_tl_m - 5 > 1275) ? 1275 : max_tl_m - 5;
			if (r < 55) begin
				if ($urandom_range(99) < 15) begin
					push_frame(8'($urandom_range(255)), 8'd1,
						$urandom_range(1) ? sld_pkg::SUB_VOLTAGE : sld_pkg::SUB_CAPACITY,
						8'd1, 0, 0);
				end else begin
					d = $urandom_range(99);
					if (d < 85)
						d = $urandom_range(0, 8);
					else if (d < 97)
						d = $urandom_range(9, 60);
					else
						d = $urandom_range(0, lim);
					if (d > lim)
						d = lim;
					push_frame(8'($urandom_range(255)), 8'($urandom_range(255)),
						8'($urandom_range(255)), 8'($urandom_range(255)), d,
						($urandom_range(99) < 70) ? 0 : $urandom_range(1, 5));
				end
			end else if (r < 70)
				send(sld_pkg::REQ_PUSH,
					($urandom_range(3) == 0) ? sync_m : 8'($urandom_range(255)),
					11'($urandom_range(2047)));
			else if (r < 85)
				send(sld_pkg::REQ_READ, 8'($urandom_range(255)),
					$urandom_range(1) ? 11'($urandom_range(15)) : 11'($urandom_range(2047)));
			else if (r < 97)
				send(sld_pkg::REQ_SERVICE, 8'($urandom_range(255)),
					11'($urandom_range(2047)));
			else
				send(sld_pkg::REQ_NONE, 8'($urandom_range(255)), 11'($urandom_range(2047)));
		end
	endtask

	initial begin
		send_pct = 12;
		recv_pct = 76;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_regs(sld_pkg::SEED_RST, sld_pkg::MAX_TL_RST, sld_pkg::SYNC_RST, sld_pkg::END_RST);

		push_frame(8'h00, 8'd1, sld_pkg::SUB_VOLTAGE, 8'd1, 0, 0);
		push_frame(8'hFF, 8'd1, sld_pkg::SUB_CAPACITY, 8'd1, 0, 0);
		push_frame(8'h12, 8'hFF, 8'h00, 8'hFF, 3, 0);
		send(sld_pkg::REQ_READ, 8'h00, 11'd0);
		send(sld_pkg::REQ_READ, 8'hFF, 11'd2);
		send(sld_pkg::REQ_READ, 8'h00, 11'd3);
		send(sld_pkg::REQ_READ, 8'h00, 11'd2047);
		push_frame(8'h01, 8'd1, sld_pkg::SUB_VOLTAGE, 8'd1, 1, 0);
		push_frame(8'h02, 8'h03, 8'h04, 8'h05, 2, 1);
		push_frame(8'h02, 8'h03, 8'h04, 8'h05, 2, 2);
		push_frame(8'h02, 8'h03, 8'h04, 8'h05, 2, 3);
		push_frame(8'h02, 8'h03, 8'h04, 8'h05, 2, 4);
		push_frame(8'h02, 8'h03, 8'h04, 8'h05, 2, 5);
		send(sld_pkg::REQ_NONE, 8'hFF, 11'h7FF);
		send(sld_pkg::REQ_SERVICE, 8'h00, 11'd0);
		push_frame(8'h7E, 8'h00, 8'h00, 8'h00, 200, 0);
		send(sld_pkg::REQ_READ, 8'h00, 11'd199);
		send(sld_pkg::REQ_READ, 8'h00, 11'd200);

		hold_req = 1'b1;
		run_random(180);
		drain();

		send_pct = 76;
		recv_pct = 12;
		write_regs(32'h0, 11'd5, 8'h00, 8'hFF);
		run_random(180);
		drain();

		send_pct = 0;
		recv_pct = 0;
		write_regs(32'hFFFF_FFFF, 11'd300, 8'hFF, 8'h00);
		run_random(180);
		drain();

		if (errors == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
